@@ src/assert_macros.svh @@
// Assertion macros shared by the random-key multiway cut cost block.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ src/rkmc_pkg.sv @@
// Package of the multiway cut cost block: widths, codes, shared types
// and the allele-to-group function. Depends on nothing.
`timescale 1ns / 1ps

package rkmc_pkg;

   localparam int MAX_VERTICES  = 1024;
   localparam int MAX_TERMINALS = 256;

   localparam int VTX_W     = $clog2(MAX_VERTICES);
   localparam int GRP_W     = 8;
   localparam int NV_W      = 11;
   localparam int NT_W      = 9;
   localparam int ALLELE_W  = 17;
   localparam int WEIGHT_W  = 16;
   localparam int COST_W    = 32;
   localparam int KIND_W    = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 11;

   typedef enum logic [KIND_W-1:0] {
      KIND_TERM   = 2'd0,
      KIND_START  = 2'd1,
      KIND_ALLELE = 2'd2,
      KIND_EDGE   = 2'd3
   } kind_type;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_VERTICES  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_TERMINALS = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_EDGE
   } state_type;

   // One store entry: terminal flag and partition group.
   typedef struct packed {
      logic             flag;
      logic [GRP_W-1:0] group;
   } entry_type;

   typedef struct packed {
      logic             we;
      logic [VTX_W-1:0] waddr;
      entry_type        wdata;
      logic             re;
      logic [VTX_W-1:0] raddr_a;
      logic [VTX_W-1:0] raddr_b;
   } mem_req_type;

   // Effective vertex and terminal counts after clamping.
   typedef struct packed {
      logic [NV_W-1:0] n;
      logic [NT_W-1:0] k;
   } cfg_type;

   typedef struct packed {
      logic clearing;
      logic in_edge;
   } stat_type;

   // Group of a Q16 allele: floor(allele * k / 65536), and k-1 for 1.0 or more.
   function automatic logic [GRP_W-1:0] allele_group(input logic [ALLELE_W-1:0] a,
                                                      input logic [NT_W-1:0] k);
      logic [ALLELE_W+NT_W-2:0] prod;
      logic [NT_W-1:0]          km1;
      prod = {{(NT_W){1'b0}}, a[ALLELE_W-2:0]}
           * {{(ALLELE_W-1){1'b0}}, k};
      km1  = k - NT_W'(1);
      if (a[ALLELE_W-1]) begin
         return km1[GRP_W-1:0];
      end
      return prod[ALLELE_W-2+GRP_W:ALLELE_W-1];
   endfunction

endpackage

@@ src/rkmc_if.sv @@
// Valid/ready channel interfaces for the request and response items.
// Depends on rkmc_pkg for field widths.
`timescale 1ns / 1ps

interface rkmc_req_if;
   logic                            valid;
   logic                            ready;
   logic [rkmc_pkg::KIND_W-1:0]     kind;
   logic [rkmc_pkg::VTX_W-1:0]      vertex_a;
   logic [rkmc_pkg::VTX_W-1:0]      vertex_b;
   logic [rkmc_pkg::ALLELE_W-1:0]   allele;
   logic [rkmc_pkg::WEIGHT_W-1:0]   weight;
   logic                            last_edge;

   modport source (output valid, kind, vertex_a, vertex_b, allele, weight, last_edge,
                   input ready);
   modport sink (input valid, kind, vertex_a, vertex_b, allele, weight, last_edge,
                 output ready);
endinterface

interface rkmc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            is_cut;
   logic [rkmc_pkg::VTX_W-1:0]      edge_source;
   logic [rkmc_pkg::VTX_W-1:0]      edge_target;
   logic [rkmc_pkg::COST_W-1:0]     running_cost;
   logic                            last;

   modport source (output valid, is_cut, edge_source, edge_target, running_cost, last,
                   input ready);
   modport sink (input valid, is_cut, edge_source, edge_target, running_cost, last,
                 output ready);
endinterface

@@ src/rkmc_store.sv @@
// Vertex store: one write port and two registered read ports over the
// terminal flags and groups of all vertices. Depends on rkmc_pkg.
`timescale 1ns / 1ps

module rkmc_store (
   input  logic                  clock,
   input  rkmc_pkg::mem_req_type mem_req,
   output rkmc_pkg::entry_type   rd_a,
   output rkmc_pkg::entry_type   rd_b
);
   import rkmc_pkg::*;

   entry_type mem [MAX_VERTICES];
   entry_type rd_a_ff;
   entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
   end

   // Read data holds while no read is issued, so a stalled edge keeps its groups.
   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         rd_a_ff <= mem[mem_req.raddr_a];
         rd_b_ff <= mem[mem_req.raddr_b];
      end
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

@@ src/rkmc_ctrl.sv @@
// Sequencer of the cut cost block: clearing pass, terminal loads, allele
// scan over terminals, edge evaluation and the response register. Uses rkmc_pkg.
`timescale 1ns / 1ps

module rkmc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   rkmc_req_if.sink              req_chan,
   rkmc_rsp_if.source            rsp_chan,
   input  rkmc_pkg::cfg_type     cfg,
   output rkmc_pkg::mem_req_type mem_req,
   input  rkmc_pkg::entry_type   rd_a,
   input  rkmc_pkg::entry_type   rd_b,
   output rkmc_pkg::stat_type    stat
);
   import rkmc_pkg::*;

   state_type           state_ff, state_in;
   logic [VTX_W-1:0]    clr_ff, clr_in;
   logic [NV_W-1:0]     cursor_ff, cursor_in;
   logic [NT_W-1:0]     loaded_ff, loaded_in;
   logic [COST_W-1:0]   cost_ff, cost_in;

   logic [GRP_W-1:0]    grp_ff;
   logic [VTX_W-1:0]    va_ff;
   logic [VTX_W-1:0]    vb_ff;
   logic [WEIGHT_W-1:0] weight_ff;
   logic                last_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                cut_o_ff;
   logic [VTX_W-1:0]    src_o_ff;
   logic [VTX_W-1:0]    tgt_o_ff;
   logic [COST_W-1:0]   cost_o_ff;
   logic                last_o_ff;

   logic                accept;
   logic                rsp_free;
   logic                rsp_load;
   logic                cut;
   logic [COST_W:0]     sum;
   logic [NV_W-1:0]     cursor_nxt;

   assign accept     = req_chan.valid && req_chan.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;
   assign cut        = rd_a.group != rd_b.group;
   assign sum        = {1'b0, cost_ff} + {{(COST_W+1-WEIGHT_W){1'b0}}, weight_ff};
   assign cursor_nxt = cursor_ff + NV_W'(1);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cursor_in    = cursor_ff;
      loaded_in    = loaded_ff;
      cost_in      = cost_ff;
      mem_req      = '0;
      rsp_load     = 1'b0;
      req_chan.ready = (state_ff == ST_IDLE);

      case (state_ff)
         ST_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = clr_ff;
            clr_in        = clr_ff + VTX_W'(1);
            if (clr_ff == VTX_W'(MAX_VERTICES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (kind_type'(req_chan.kind))
                  KIND_TERM: begin
                     if ({1'b0, req_chan.vertex_a} < cfg.n && loaded_ff < cfg.k) begin
                        mem_req.we          = 1'b1;
                        mem_req.waddr       = req_chan.vertex_a;
                        mem_req.wdata.flag  = 1'b1;
                        mem_req.wdata.group = loaded_ff[GRP_W-1:0];
                        loaded_in           = loaded_ff + NT_W'(1);
                     end
                  end
                  KIND_START: begin
                     cost_in   = '0;
                     cursor_in = '0;
                  end
                  KIND_ALLELE: begin
                     if (cursor_ff >= cfg.n) begin
                        cursor_in = cfg.n;
                     end else begin
                        mem_req.re      = 1'b1;
                        mem_req.raddr_a = cursor_ff[VTX_W-1:0];
                        state_in        = ST_SCAN;
                     end
                  end
                  KIND_EDGE: begin
                     mem_req.re      = 1'b1;
                     mem_req.raddr_a = req_chan.vertex_a;
                     mem_req.raddr_b = req_chan.vertex_b;
                     state_in        = ST_EDGE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (rd_a.flag) begin
               // Terminal vertex: step over it and look at the next one.
               cursor_in = cursor_nxt;
               if (cursor_nxt >= cfg.n) begin
                  state_in = ST_IDLE;
               end else begin
                  mem_req.re      = 1'b1;
                  mem_req.raddr_a = cursor_nxt[VTX_W-1:0];
               end
            end else begin
               mem_req.we          = 1'b1;
               mem_req.waddr       = cursor_ff[VTX_W-1:0];
               mem_req.wdata.flag  = 1'b0;
               mem_req.wdata.group = grp_ff;
               cursor_in           = cursor_nxt;
               state_in            = ST_IDLE;
            end
         end
         ST_EDGE: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               if (cut) begin
                  cost_in = sum[COST_W] ? '1 : sum[COST_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cursor_ff    <= '0;
         loaded_ff    <= '0;
         cost_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cursor_ff    <= cursor_in;
         loaded_ff    <= loaded_in;
         cost_ff      <= cost_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         grp_ff    <= allele_group(req_chan.allele, cfg.k);
         va_ff     <= req_chan.vertex_a;
         vb_ff     <= req_chan.vertex_b;
         weight_ff <= req_chan.weight;
         last_ff   <= req_chan.last_edge;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         cut_o_ff  <= cut;
         src_o_ff  <= va_ff;
         tgt_o_ff  <= vb_ff;
         cost_o_ff <= cost_in;
         last_o_ff <= last_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.is_cut       = cut_o_ff;
   assign rsp_chan.edge_source  = src_o_ff;
   assign rsp_chan.edge_target  = tgt_o_ff;
   assign rsp_chan.running_cost = cost_o_ff;
   assign rsp_chan.last         = last_o_ff;

   assign stat.clearing = (state_ff == ST_CLEAR);
   assign stat.in_edge  = (state_ff == ST_EDGE);

endmodule

@@ src/random_key_multiway_cut_cost.sv @@
// Top level of the random-key multiway cut cost block: configuration registers,
// vertex store and sequencer. Depends on rkmc_pkg, rkmc_if, rkmc_store, rkmc_ctrl.
`timescale 1ns / 1ps
//
// Usage. Items arrive on req_chan (valid/ready). Terminal-load items mark a
// vertex as a terminal and give it the next group number. A start item clears
// the running cost and the vertex cursor. Allele items assign groups to the
// non-terminal vertices in increasing order. Each edge item yields one result
// item on rsp_chan with the cut flag, both endpoints and the saturating cost.
// The csr_ port writes the vertex count (index 0) and terminal count (index 1);
// the user must write it only while the block is idle; the block does not enforce this.
// Timing. Terminal-load and start items are handled in the idle state. An edge
// item reads the groups of both endpoints from the store on acceptance, then
// compares them and adds the weight in the evaluation state; its result is
// registered there, once the output register is free. An allele item reads the
// cursor entry, then steps over terminal vertices as the scan reads one store
// entry per cycle through a single read port.
// Reset. After reset the block sweeps the 1024-entry store clear, one entry per
// cycle, and req_chan.ready stays low until the sweep ends. Configuration writes
// are taken during the sweep.
// Stalls. A result waits in the output register while rsp_chan.ready is low;
// further items are still accepted until another edge item is accepted and waits.

module random_key_multiway_cut_cost (
   input  logic                               clock,
   input  logic                               reset,
   rkmc_req_if.sink                           req_chan,
   rkmc_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [rkmc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rkmc_pkg::CSR_W-1:0]         csr_wdata
);
   import rkmc_pkg::*;

`include "assert_macros.svh"

   logic [NV_W-1:0] nv_ff;
   logic [NT_W-1:0] nt_ff;
   cfg_type         cfg;
   mem_req_type     mem_req;
   entry_type       rd_a;
   entry_type       rd_b;
   stat_type        stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         nv_ff <= NV_W'(MAX_VERTICES);
         nt_ff <= NT_W'(2);
      end else if (csr_we) begin
         case (csr_index)
            CSR_NUM_VERTICES:  nv_ff <= csr_wdata[NV_W-1:0];
            CSR_NUM_TERMINALS: nt_ff <= csr_wdata[NT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Effective counts: a zero reads as one, and values clamp at the maxima.
   always_comb begin
      if (nv_ff == '0) begin
         cfg.n = NV_W'(1);
      end else if (nv_ff > NV_W'(MAX_VERTICES)) begin
         cfg.n = NV_W'(MAX_VERTICES);
      end else begin
         cfg.n = nv_ff;
      end
      if (nt_ff == '0) begin
         cfg.k = NT_W'(1);
      end else if (nt_ff > NT_W'(MAX_TERMINALS)) begin
         cfg.k = NT_W'(MAX_TERMINALS);
      end else begin
         cfg.k = nt_ff;
      end
   end

   rkmc_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_a    (rd_a),
      .rd_b    (rd_b)
   );

   rkmc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cfg      (cfg),
      .mem_req  (mem_req),
      .rd_a     (rd_a),
      .rd_b     (rd_b),
      .stat     (stat)
   );

   // No item is taken while the store is being swept clear.
   `ASSERT_SAME(a_no_accept_clearing, clock, reset, stat.clearing, !req_chan.ready)
   // An accepted edge item always moves into the evaluation step.
   `ASSERT_NEXT(a_edge_evaluates, clock, reset,
                req_chan.valid && req_chan.ready && req_chan.kind == KIND_EDGE, stat.in_edge)
   // A new result appears only out of the evaluation step.
   `ASSERT_SAME(a_rsp_from_edge, clock, reset, $rose(rsp_chan.valid), $past(stat.in_edge))

endmodule
